/* sv/cct_pkg.sv */
// package for the calendar clock: date and time types, limits and month lengths
`default_nettype none

package cct_pkg;

  localparam int YearW   = 16;
  localparam int MonthW  = 4;
  localparam int DayW    = 5;
  localparam int HourW   = 5;
  localparam int MinuteW = 6;
  localparam int SecondW = 6;

  localparam logic [YearW-1:0]   ResetYear = 16'd2019;
  localparam logic [MonthW-1:0]  MonthMax  = 4'd12;
  localparam logic [HourW-1:0]   HourMax   = 5'd24;
  localparam logic [MinuteW-1:0] MinuteMax = 6'd60;
  localparam logic [SecondW-1:0] SecondMax = 6'd60;

  // operation codes
  localparam logic OpTick = 1'b0;
  localparam logic OpSet  = 1'b1;

  // multiplicative inverse of 25 modulo 2^16, and the largest product of a multiple of 25
  localparam logic [YearW-1:0] Inv25     = 16'd23593;
  localparam logic [YearW-1:0] Div25Max  = 16'd2621;

  typedef struct packed {
    logic [YearW-1:0]   year;
    logic [MonthW-1:0]  month;
    logic [DayW-1:0]    day;
    logic [HourW-1:0]   hour;
    logic [MinuteW-1:0] minute;
    logic [SecondW-1:0] second;
  } date_time_t;

  // gregorian leap year: by 400, or by 4 and not by 100
  function automatic logic is_leap(input logic [YearW-1:0] y);
    logic [YearW-1:0] prod;
    logic             div25;
    logic             div4;
    logic             div16;
    prod  = y * Inv25;
    div25 = (prod <= Div25Max);
    div4  = (y[1:0] == 2'd0);
    div16 = (y[3:0] == 4'd0);
    return (div16 && div25) || (div4 && !div25);
  endfunction

  // days in a month, 31 for codes outside 1..12
  function automatic logic [DayW-1:0] month_days(input logic [MonthW-1:0] m,
                                                 input logic leap);
    logic [DayW-1:0] d;
    case (m)
      4'd2:                        d = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:     d = 5'd30;
      default:                     d = 5'd31;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

/* sv/cct_calc.sv */
// next date and time for one transaction: tick with carry ripple, or validated load
`default_nettype none

module cct_calc (
  input  wire logic                 op,
  input  wire cct_pkg::date_time_t  cur,
  input  wire cct_pkg::date_time_t  load,
  output cct_pkg::date_time_t       nxt,
  output logic                      bad
);

  logic [cct_pkg::YearW-1:0] leap_year;
  logic                      leap;
  logic [cct_pkg::DayW-1:0]  mlen;
  logic                      sec_wrap;
  logic                      min_wrap;
  logic                      hour_wrap;
  logic                      day_wrap;
  logic                      month_wrap;
  logic                      month_ok;
  logic                      ok;
  cct_pkg::date_time_t       ticked;

  // one leap test and month length, shared by tick and load
  always_comb begin
    leap_year = (op == cct_pkg::OpSet) ? load.year : cur.year;
    leap      = cct_pkg::is_leap(leap_year);
    mlen      = cct_pkg::month_days((op == cct_pkg::OpSet) ? load.month : cur.month, leap);
  end

  // tick: carries ripple from second up to year
  always_comb begin
    sec_wrap   = (cur.second >= cct_pkg::SecondMax);
    min_wrap   = sec_wrap && (cur.minute >= cct_pkg::MinuteMax);
    hour_wrap  = min_wrap && (cur.hour >= cct_pkg::HourMax);
    day_wrap   = hour_wrap && (cur.day >= mlen);
    month_wrap = day_wrap && (cur.month >= cct_pkg::MonthMax);

    ticked.second = sec_wrap ? cct_pkg::SecondW'(1) : cur.second + cct_pkg::SecondW'(1);
    ticked.minute = !sec_wrap ? cur.minute :
                    (min_wrap ? cct_pkg::MinuteW'(1) : cur.minute + cct_pkg::MinuteW'(1));
    ticked.hour   = !min_wrap ? cur.hour :
                    (hour_wrap ? cct_pkg::HourW'(1) : cur.hour + cct_pkg::HourW'(1));
    ticked.day    = !hour_wrap ? cur.day :
                    (day_wrap ? cct_pkg::DayW'(1) : cur.day + cct_pkg::DayW'(1));
    ticked.month  = !day_wrap ? cur.month :
                    (month_wrap ? cct_pkg::MonthW'(1) : cur.month + cct_pkg::MonthW'(1));
    ticked.year   = month_wrap ? cur.year + cct_pkg::YearW'(1) : cur.year;
  end

  // load: range checks, day checked only against a real month
  always_comb begin
    month_ok = (load.month != '0) && (load.month <= cct_pkg::MonthMax);
    ok = month_ok
         && (load.day != '0) && (load.day <= mlen)
         && (load.hour != '0) && (load.hour <= cct_pkg::HourMax)
         && (load.minute != '0) && (load.minute <= cct_pkg::MinuteMax)
         && (load.second != '0) && (load.second <= cct_pkg::SecondMax);
  end

  // select result
  always_comb begin
    if (op == cct_pkg::OpSet) begin
      bad = !ok;
      if (ok) begin
        nxt = load;
      end else begin
        nxt.year   = load.year;
        nxt.month  = cct_pkg::MonthW'(1);
        nxt.day    = cct_pkg::DayW'(1);
        nxt.hour   = cct_pkg::HourW'(1);
        nxt.minute = cct_pkg::MinuteW'(1);
        nxt.second = cct_pkg::SecondW'(1);
      end
    end else begin
      bad = 1'b0;
      nxt = ticked;
    end
  end

endmodule

`default_nettype wire

/* sv/calendar_clock_tick.sv */
// calendar clock top level: input register, clock state and result register
// Usage
//   Input channel: item_valid / item_stall carry one transaction, either a
//   one-second tick (op = 0) or a set of date and time (op = 1, set_* fields).
//   Output channel: result_valid / result_stall carry one result per input
//   transaction, the date and time after it and set_invalid for a rejected set.
//   Path: a transaction is held in the input register, and its result is
//   written into the clock state when the input register advances.
//   Throughput: one transaction per cycle while no result is stalled; the
//   input register and the clock state (which doubles as the result register)
//   each hold one transaction, and all next-state logic sits between them.
//   Stall: while result_stall holds a waiting result, one further transaction
//   is taken into the input register and then item_stall rises until the
//   result is taken. A stalled result does not change.
//   Reset: synchronous, active high; the clock goes to 2019-01-01 01:01:01,
//   no result is pending and the input register is empty.
`default_nettype none

module calendar_clock_tick (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          item_valid,
  output logic                               item_stall,
  input  wire logic                          op,
  input  wire logic [cct_pkg::YearW-1:0]     set_year,
  input  wire logic [cct_pkg::MonthW-1:0]    set_month,
  input  wire logic [cct_pkg::DayW-1:0]      set_day,
  input  wire logic [cct_pkg::HourW-1:0]     set_hour,
  input  wire logic [cct_pkg::MinuteW-1:0]   set_minute,
  input  wire logic [cct_pkg::SecondW-1:0]   set_second,
  output logic                               result_valid,
  input  wire logic                          result_stall,
  output logic [cct_pkg::YearW-1:0]          cur_year,
  output logic [cct_pkg::MonthW-1:0]         cur_month,
  output logic [cct_pkg::DayW-1:0]           cur_day,
  output logic [cct_pkg::HourW-1:0]          cur_hour,
  output logic [cct_pkg::MinuteW-1:0]        cur_minute,
  output logic [cct_pkg::SecondW-1:0]        cur_second,
  output logic                               set_invalid
);

  logic                pending;
  logic                item_op;
  cct_pkg::date_time_t item_load;
  cct_pkg::date_time_t clock_state;
  cct_pkg::date_time_t clock_next;
  logic                bad_next;
  logic                accept;
  logic                advance;

  // handshake
  assign advance    = pending && !(result_valid && result_stall);
  assign item_stall = pending && result_valid && result_stall;
  assign accept     = item_valid && !item_stall;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b0;
    end else if (accept) begin
      pending <= 1'b1;
    end else if (advance) begin
      pending <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_op          <= op;
      item_load.year   <= set_year;
      item_load.month  <= set_month;
      item_load.day    <= set_day;
      item_load.hour   <= set_hour;
      item_load.minute <= set_minute;
      item_load.second <= set_second;
    end
  end

  // next date and time
  cct_calc u_calc (
    .op   (item_op),
    .cur  (clock_state),
    .load (item_load),
    .nxt  (clock_next),
    .bad  (bad_next)
  );

  // clock state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid       <= 1'b0;
      clock_state.year   <= cct_pkg::ResetYear;
      clock_state.month  <= cct_pkg::MonthW'(1);
      clock_state.day    <= cct_pkg::DayW'(1);
      clock_state.hour   <= cct_pkg::HourW'(1);
      clock_state.minute <= cct_pkg::MinuteW'(1);
      clock_state.second <= cct_pkg::SecondW'(1);
    end else if (advance) begin
      result_valid <= 1'b1;
      clock_state  <= clock_next;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      set_invalid <= bad_next;
    end
  end

  // result fields
  assign cur_year   = clock_state.year;
  assign cur_month  = clock_state.month;
  assign cur_day    = clock_state.day;
  assign cur_hour   = clock_state.hour;
  assign cur_minute = clock_state.minute;
  assign cur_second = clock_state.second;

endmodule

`default_nettype wire
